FILE: hw/rtl/tcss_pkg.sv
package tcss_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int CFG_INDEX_W   = 1;
    localparam int SQRT_STEPS    = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACCEL_STEPS    = 1'b0,
        REG_STEPS_PER_UNIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_SINGLE_ROOT = 2'd0,
        KIND_SMALL_ROOT  = 2'd1,
        KIND_INFEASIBLE  = 2'd2,
        KIND_ZERO_ACCEL  = 2'd3
    } kind_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] move_distance;
        logic [WORD_W-1:0]        move_time;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] cruise_speed;
        kind_t                    solution_kind;
    } rsp_t;

endpackage

FILE: hw/rtl/tcss_div.sv
// Restoring divider, one quotient bit per stage, NW stages.
module tcss_div #(
    parameter int NW = 81,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          valid_out,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [NW];
    logic [DW-1:0] rem_reg   [NW];
    logic [NW-1:0] nq_reg    [NW];
    logic [DW-1:0] den_reg   [NW];
    logic [SW-1:0] side_reg  [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_stage
            logic          vp;
            logic [DW-1:0] rp;
            logic [NW-1:0] qp;
            logic [DW-1:0] dp;
            logic [SW-1:0] sp;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;
            logic [DW-1:0] rem_next;
            logic [NW-1:0] nq_next;

            if (k == 0)
            begin : g_first
                assign vp = valid_in;
                assign rp = '0;
                assign qp = num;
                assign dp = den;
                assign sp = side_in;
            end
            else
            begin : g_rest
                assign vp = valid_reg[k-1];
                assign rp = rem_reg[k-1];
                assign qp = nq_reg[k-1];
                assign dp = den_reg[k-1];
                assign sp = side_reg[k-1];
            end

            // numerator bits shift out the top, quotient bits shift in below
            assign trial    = {rp, qp[NW-1]};
            assign diff     = trial - {1'b0, dp};
            assign ge       = (trial >= {1'b0, dp});
            assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            assign nq_next  = {qp[NW-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= vp;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    nq_reg[k]   <= nq_next;
                    den_reg[k]  <= dp;
                    side_reg[k] <= sp;
                end
            end
        end
    endgenerate

    assign valid_out = valid_reg[NW-1];
    assign quo       = nq_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

FILE: hw/rtl/trapezoid_cruise_speed_solver.sv
// Request beats pass through the parallel pair of bit-serial divider pipelines, the 32-stage square root
// pipeline and a third divider pipeline, in that order, before reaching the response.
// Throughput: one beat per cycle while the skid entry is empty; a two-entry output stage keeps req_ready registered.
// Reset: asynchronous active-low rst_n empties the pipeline and sets accel_steps to 0
// and steps_per_unit to 1.0.
module trapezoid_cruise_speed_solver
    import tcss_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_reg_t          cfg_index,
    input  logic [WORD_W-1:0] cfg_data,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp
);

    localparam int NW1     = FRAC_BITS + 65;
    localparam int NW3     = FRAC_BITS + 33;
    localparam int ROOT_W  = SQRT_STEPS;
    localparam int RAD_W   = 2 * SQRT_STEPS;
    localparam int REM_W   = SQRT_STEPS + 2;
    localparam int SIDE1_W = 65;
    localparam int SIDE2_W = 64;
    localparam int SIDE3_W = ROOT_W + 4;
    localparam logic [WORD_W-1:0] SPU_RESET = WORD_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] d;
        logic              feas;
        logic              zd;
        logic              az;
    } sq_side_t;

    logic [WORD_W-1:0] accel_reg;
    logic [WORD_W-1:0] spu_reg;
    logic [WORD_W-1:0] s_eff;
    logic              en;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= '0;
            spu_reg   <= SPU_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ACCEL_STEPS:    accel_reg <= cfg_data;
                REG_STEPS_PER_UNIT: spu_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign s_eff = (spu_reg == '0) ? WORD_W'(1) : spu_reg;

    // stage A: capture, take magnitude
    logic              a_valid_reg;
    logic [WORD_W-1:0] a_d_reg;
    logic [WORD_W-1:0] a_t_reg;
    logic [WORD_W-1:0] req_mag;

    assign req_ready = en;
    assign req_mag   = req.move_distance[WORD_W-1] ? (~req.move_distance + WORD_W'(1))
                                                   : req.move_distance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_d_reg <= req_mag;
            a_t_reg <= req.move_time;
        end
    end

    // stage B: products
    logic              b_valid_reg;
    logic [63:0]       b_ds_reg;
    logic [63:0]       b_da_reg;
    logic [63:0]       b_t2_reg;
    logic [WORD_W-1:0] b_t_reg;
    logic [WORD_W-1:0] b_d_reg;
    logic              b_az_reg;
    logic [63:0]       b_ds_next;
    logic [63:0]       b_da_next;
    logic [63:0]       b_t2_next;

    assign b_ds_next = a_d_reg * s_eff;
    assign b_da_next = a_d_reg * accel_reg;
    assign b_t2_next = a_t_reg * a_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ds_reg <= b_ds_next;
            b_da_reg <= b_da_next;
            b_t2_reg <= b_t2_next;
            b_t_reg  <= a_t_reg;
            b_d_reg  <= a_d_reg;
            b_az_reg <= (accel_reg == '0);
        end
    end

    // 4|D|/A in Q.2F and |D|*A for the infeasible case, in parallel
    logic               q_valid;
    logic [NW1-1:0]     q_quo;
    logic [SIDE1_W-1:0] q_side;
    logic               x_valid;
    logic [NW1-1:0]     x_quo;
    logic [SIDE2_W-1:0] x_side;

    tcss_div #(
        .NW (NW1),
        .DW (WORD_W),
        .SW (SIDE1_W)
    ) u_div_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (b_valid_reg),
        .num       ({b_ds_reg[62:0], {(FRAC_BITS + 2){1'b0}}}),
        .den       (accel_reg),
        .side_in   ({b_t2_reg, b_az_reg}),
        .valid_out (q_valid),
        .quo       (q_quo),
        .side_out  (q_side)
    );

    tcss_div #(
        .NW (NW1),
        .DW (WORD_W),
        .SW (SIDE2_W)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (b_valid_reg),
        .num       ({1'b0, b_da_reg, {FRAC_BITS{1'b0}}}),
        .den       (s_eff),
        .side_in   ({b_t_reg, b_d_reg}),
        .valid_out (x_valid),
        .quo       (x_quo),
        .side_out  (x_side)
    );

    // stage P: saturate quotients
    logic              p_valid_reg;
    logic [63:0]       p_q_reg;
    logic [62:0]       p_x_reg;
    logic [63:0]       p_t2_reg;
    logic              p_az_reg;
    logic [WORD_W-1:0] p_t_reg;
    logic [WORD_W-1:0] p_d_reg;
    logic [63:0]       p_q_next;
    logic [62:0]       p_x_next;
    logic              x_big;

    assign p_q_next = (|q_quo[NW1-1:64]) ? '1 : q_quo[63:0];
    assign x_big    = (|x_quo[NW1-1:63]) || (x_quo[62] && (|x_quo[61:0]));
    assign p_x_next = x_big ? 63'h4000000000000000 : x_quo[62:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= q_valid && x_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_q_reg  <= p_q_next;
            p_x_reg  <= p_x_next;
            p_t2_reg <= q_side[SIDE1_W-1:1];
            p_az_reg <= q_side[0];
            p_t_reg  <= x_side[SIDE2_W-1:WORD_W];
            p_d_reg  <= x_side[WORD_W-1:0];
        end
    end

    // stage M: discriminant, pick the radicand
    logic           m_valid_reg;
    logic [63:0]    m_rad_reg;
    sq_side_t       m_side_reg;
    logic           m_feas;
    logic [63:0]    m_disc;
    logic [63:0]    m_rad_next;
    sq_side_t       m_side_next;

    assign m_feas     = (p_t2_reg >= p_q_reg);
    assign m_disc     = p_t2_reg - p_q_reg;
    assign m_rad_next = m_feas ? m_disc : {1'b0, p_x_reg};

    always_comb
    begin
        m_side_next.t    = p_t_reg;
        m_side_next.d    = p_d_reg;
        m_side_next.feas = m_feas;
        m_side_next.zd   = (p_t2_reg == p_q_reg);
        m_side_next.az   = p_az_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_rad_reg  <= m_rad_next;
            m_side_reg <= m_side_next;
        end
    end

    // square root, two radicand bits per stage
    logic              sq_valid_reg [SQRT_STEPS];
    logic [RAD_W-1:0]  sq_rad_reg   [SQRT_STEPS];
    logic [REM_W-1:0]  sq_rem_reg   [SQRT_STEPS];
    logic [ROOT_W-1:0] sq_root_reg  [SQRT_STEPS];
    sq_side_t          sq_side_reg  [SQRT_STEPS];

    genvar j;
    generate
        for (j = 0; j < SQRT_STEPS; j++)
        begin : g_sqrt
            logic              vp;
            logic [RAD_W-1:0]  radp;
            logic [REM_W-1:0]  remp;
            logic [ROOT_W-1:0] rootp;
            sq_side_t          sidep;
            logic [REM_W+1:0]  tr;
            logic [REM_W+1:0]  cand;
            logic [REM_W+1:0]  diff;
            logic              ge;
            logic [REM_W-1:0]  rem_next;

            if (j == 0)
            begin : g_first
                assign vp    = m_valid_reg;
                assign radp  = m_rad_reg;
                assign remp  = '0;
                assign rootp = '0;
                assign sidep = m_side_reg;
            end
            else
            begin : g_rest
                assign vp    = sq_valid_reg[j-1];
                assign radp  = sq_rad_reg[j-1];
                assign remp  = sq_rem_reg[j-1];
                assign rootp = sq_root_reg[j-1];
                assign sidep = sq_side_reg[j-1];
            end

            assign tr       = {remp, radp[RAD_W-1:RAD_W-2]};
            assign cand     = {2'b00, rootp, 2'b01};
            assign diff     = tr - cand;
            assign ge       = (tr >= cand);
            assign rem_next = ge ? diff[REM_W-1:0] : tr[REM_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_valid_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    sq_valid_reg[j] <= vp;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rad_reg[j]  <= {radp[RAD_W-3:0], 2'b00};
                    sq_rem_reg[j]  <= rem_next;
                    sq_root_reg[j] <= {rootp[ROOT_W-2:0], ge};
                    sq_side_reg[j] <= sidep;
                end
            end
        end
    endgenerate

    // stage D: feasible speed is 2|D| / (T + sqrt(disc))
    logic              d_valid_reg;
    logic [NW3-1:0]    d_num_reg;
    logic [WORD_W:0]   d_den_reg;
    logic [SIDE3_W-1:0] d_side_reg;
    sq_side_t          sq_last;
    logic [ROOT_W-1:0] sq_w;

    assign sq_last = sq_side_reg[SQRT_STEPS-1];
    assign sq_w    = sq_root_reg[SQRT_STEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= sq_valid_reg[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_num_reg  <= {sq_last.d, 1'b0, {FRAC_BITS{1'b0}}};
            d_den_reg  <= {1'b0, sq_last.t} + {1'b0, sq_w};
            d_side_reg <= {sq_w, sq_last.feas, sq_last.zd, sq_last.az,
                           (sq_last.t == '0) && (sq_w == '0)};
        end
    end

    logic               s_valid;
    logic [NW3-1:0]     s_quo;
    logic [SIDE3_W-1:0] s_side;

    tcss_div #(
        .NW (NW3),
        .DW (WORD_W + 1),
        .SW (SIDE3_W)
    ) u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (d_valid_reg),
        .num       (d_num_reg),
        .den       (d_den_reg),
        .side_in   (d_side_reg),
        .valid_out (s_valid),
        .quo       (s_quo),
        .side_out  (s_side)
    );

    // result select
    logic [ROOT_W-1:0] f_w;
    logic              f_feas;
    logic              f_zd;
    logic              f_az;
    logic              f_dz;
    rsp_t              f_rsp;

    assign {f_w, f_feas, f_zd, f_az, f_dz} = s_side;

    always_comb
    begin
        if (f_az)
        begin
            f_rsp.cruise_speed  = '0;
            f_rsp.solution_kind = KIND_ZERO_ACCEL;
        end
        else if (f_feas)
        begin
            if (f_dz)
                f_rsp.cruise_speed = '0;
            else if (|s_quo[NW3-1:WORD_W-1])
                f_rsp.cruise_speed = {1'b0, {(WORD_W - 1){1'b1}}};
            else
                f_rsp.cruise_speed = {1'b0, s_quo[WORD_W-2:0]};
            f_rsp.solution_kind = f_zd ? KIND_SINGLE_ROOT : KIND_SMALL_ROOT;
        end
        else
        begin
            f_rsp.cruise_speed  = WORD_W'(0) - f_w;
            f_rsp.solution_kind = KIND_INFEASIBLE;
        end
    end

    // output register plus skid entry; pipeline stalls only when the skid is full
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    logic skid_valid_reg;
    logic skid_valid_next;
    rsp_t skid_reg;
    logic take;
    logic incoming;
    logic load_rsp;
    logic load_skid;
    logic rsp_from_skid;

    assign en       = !skid_valid_reg;
    assign take     = rsp_valid_reg && rsp_ready;
    assign incoming = en && s_valid;

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_rsp        = 1'b0;
        load_skid       = 1'b0;
        rsp_from_skid   = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                rsp_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (incoming)
        begin
            if (!rsp_valid_reg || take)
            begin
                load_rsp       = 1'b1;
                rsp_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg  <= rsp_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_from_skid)
            rsp_reg <= skid_reg;
        else if (load_rsp)
            rsp_reg <= f_rsp;
        if (load_skid)
            skid_reg <= f_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
